// File: hdl/erdo_pkg.sv
// ----------------------------------------------------------------------------
// erdo_pkg
// Shared types and constants of the expert route dedup / offset block.
// ----------------------------------------------------------------------------
package erdo_pkg;

  localparam int ID_W      = 16;
  localparam int LAYER_W   = 8;
  localparam int POS_W     = 6;
  localparam int SLOT_W    = 7;
  localparam int UEXP_W    = 12;
  localparam int OFF_W     = 48;
  localparam int TOT_W     = 7;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 1'b1;

  localparam logic [CFG_W-1:0]   RECORD_SIZE_RST = 32'd9400320;
  localparam logic [LAYER_W-1:0] LAYER_COUNT_RST = 8'd3;

  // slot code for inactive ids and error results
  localparam logic [SLOT_W-1:0] SLOT_NONE = '1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_POISON  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_ERR_OUT,
    ST_ID_RD,
    ST_ID_CHK,
    ST_TAB_CMP,
    ST_E_RD,
    ST_E_TAB,
    ST_E_IDX,
    ST_E_MUL,
    ST_E_OUT
  } state_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [UEXP_W-1:0]  expert;
  } off_req_t;

endpackage

// File: hdl/erdo_offset.sv
// ----------------------------------------------------------------------------
// erdo_offset
// Two-stage record offset unit: (layer*EXPERTS + expert) * record_size.
// ----------------------------------------------------------------------------
module erdo_offset #(
  parameter int EXPERTS = 128
) (
  input  logic                                clk,
  input  erdo_pkg::off_req_t                  req,
  input  logic [erdo_pkg::CFG_W-1:0]          record_size,
  output logic [erdo_pkg::OFF_W-1:0]          offset
);
  import erdo_pkg::*;

  localparam int EXP_W  = $clog2(EXPERTS);
  localparam int IDX_W  = LAYER_W + EXP_W;
  localparam int PROD_W = IDX_W + CFG_W;

  logic [IDX_W-1:0]  idx_q;
  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk) begin
    idx_q  <= IDX_W'(req.layer) * IDX_W'(EXPERTS) + IDX_W'(req.expert[EXP_W-1:0]);
    prod_q <= PROD_W'(idx_q) * PROD_W'(record_size);
  end

  assign offset = OFF_W'(prod_q);

endmodule

// File: hdl/erdo_core.sv
// ----------------------------------------------------------------------------
// erdo_core
// Batch collection, sequential dedup scan and result emission.
// ----------------------------------------------------------------------------
module erdo_core #(
  parameter int SLOTS   = 9,
  parameter int EXPERTS = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [erdo_pkg::ID_W-1:0]        expert_id,
  input  logic [erdo_pkg::LAYER_W-1:0]     layer,
  input  logic                             last,
  input  logic [erdo_pkg::LAYER_W-1:0]     layer_count,
  output erdo_pkg::off_req_t               off_req,
  input  logic [erdo_pkg::OFF_W-1:0]       off_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [erdo_pkg::POS_W-1:0]       position,
  output logic [erdo_pkg::SLOT_W-1:0]      mapped_slot,
  output logic                             new_entry,
  output logic [erdo_pkg::UEXP_W-1:0]      unique_expert,
  output logic [erdo_pkg::OFF_W-1:0]       record_offset,
  output logic [erdo_pkg::TOT_W-1:0]       unique_total,
  output logic [1:0]                       status,
  output logic                             final_res
);
  import erdo_pkg::*;

  localparam int EXP_W = $clog2(EXPERTS);
  localparam int IDB_W = EXP_W + 1;                 // {inactive, id}
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int SI_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SB_W  = SI_W + 2;                  // {active, new, slot}

  state_t state, state_next;

  // storage
  logic [IDB_W-1:0] id_buf   [SLOTS];
  logic [EXP_W-1:0] uniq_tab [SLOTS];
  logic [SB_W-1:0]  slot_buf [SLOTS];

  // control and batch registers
  logic [CNT_W-1:0]   len;
  logic               ovf;
  logic               bad;
  logic               sticky;
  logic [CNT_W-1:0]   n_q;
  logic [LAYER_W-1:0] layer_q;
  status_t            stat_q;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   s;
  logic [CNT_W-1:0]   used;

  // read data registers
  logic [IDB_W-1:0] id_q;
  logic [EXP_W-1:0] tab_q;
  logic [SB_W-1:0]  sb_q;

  // combinational control
  logic             acc;
  logic             id_bad;
  logic             room;
  logic             ovf_all;
  logic             bad_all;
  status_t          batch_stat;
  logic             last_pos;
  logic             hit_new;
  logic             match;
  logic             id_we;
  logic             tab_we;
  logic             tab_re;
  logic [SI_W-1:0]  tab_raddr;
  logic             sb_we;
  logic [SB_W-1:0]  sb_wdata;
  logic             pos_step;
  logic             batch_ok;

  assign acc      = in_valid && !in_stall;
  assign id_bad   = ($signed(expert_id) < -16'sd1) ||
                    ($signed(expert_id) >= $signed(ID_W'(EXPERTS)));
  assign room     = (len < CNT_W'(SLOTS));
  assign ovf_all  = ovf || !room;
  assign bad_all  = bad || id_bad;
  assign last_pos = (pos == n_q - CNT_W'(1));
  assign hit_new  = (s == used);
  assign match    = (tab_q == id_q[EXP_W-1:0]);
  assign batch_ok = (stat_q == STAT_OK);

  // overflow and layer checks take precedence over poison
  always_comb begin
    if (ovf_all || (layer >= layer_count)) begin
      batch_stat = STAT_INVALID;
    end else if (sticky) begin
      batch_stat = STAT_POISON;
    end else if (bad_all) begin
      batch_stat = STAT_INVALID;
    end else begin
      batch_stat = STAT_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (in_valid && last) begin
          state_next = (batch_stat == STAT_OK) ? ST_ID_RD : ST_ERR_OUT;
        end
      end
      ST_ERR_OUT: begin
        if (!out_stall && last_pos) state_next = ST_COLLECT;
      end
      ST_ID_RD: state_next = ST_ID_CHK;
      ST_ID_CHK: begin
        if (id_q[IDB_W-1] || hit_new) begin
          state_next = last_pos ? ST_E_RD : ST_ID_RD;
        end else begin
          state_next = ST_TAB_CMP;
        end
      end
      ST_TAB_CMP: begin
        if (match) begin
          state_next = last_pos ? ST_E_RD : ST_ID_RD;
        end else begin
          state_next = ST_ID_CHK;
        end
      end
      ST_E_RD:  state_next = ST_E_TAB;
      ST_E_TAB: state_next = sb_q[SI_W] ? ST_E_IDX : ST_E_OUT;
      ST_E_IDX: state_next = ST_E_MUL;
      ST_E_MUL: state_next = ST_E_OUT;
      ST_E_OUT: begin
        if (!out_stall) state_next = last_pos ? ST_COLLECT : ST_E_RD;
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    id_we     = 1'b0;
    tab_we    = 1'b0;
    tab_re    = 1'b0;
    tab_raddr = s[SI_W-1:0];
    sb_we     = 1'b0;
    sb_wdata  = '0;
    pos_step  = 1'b0;
    case (state)
      ST_COLLECT: begin
        in_stall = 1'b0;
        id_we    = in_valid && room;
      end
      ST_ERR_OUT: begin
        out_valid = 1'b1;
        pos_step  = !out_stall;
      end
      ST_ID_CHK: begin
        if (id_q[IDB_W-1]) begin
          sb_we    = 1'b1;
          pos_step = 1'b1;
        end else if (hit_new) begin
          tab_we   = 1'b1;
          sb_we    = 1'b1;
          sb_wdata = {1'b1, 1'b1, used[SI_W-1:0]};
          pos_step = 1'b1;
        end else begin
          tab_re = 1'b1;
        end
      end
      ST_TAB_CMP: begin
        if (match) begin
          sb_we    = 1'b1;
          sb_wdata = {1'b1, 1'b0, s[SI_W-1:0]};
          pos_step = 1'b1;
        end
      end
      ST_E_TAB: begin
        tab_raddr = sb_q[SI_W-1:0];
        tab_re    = sb_q[SI_W];
      end
      ST_E_OUT: begin
        out_valid = 1'b1;
        pos_step  = !out_stall;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (id_we) id_buf[len[SI_W-1:0]] <= {expert_id[ID_W-1], expert_id[EXP_W-1:0]};
    if (state == ST_ID_RD) id_q <= id_buf[pos[SI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tab_we) uniq_tab[used[SI_W-1:0]] <= id_q[EXP_W-1:0];
    if (tab_re) tab_q <= uniq_tab[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (sb_we) slot_buf[pos[SI_W-1:0]] <= sb_wdata;
    if (state == ST_E_RD) sb_q <= slot_buf[pos[SI_W-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_COLLECT;
      len    <= '0;
      ovf    <= 1'b0;
      bad    <= 1'b0;
      sticky <= 1'b0;
      n_q    <= '0;
      pos    <= '0;
      s      <= '0;
      used   <= '0;
      stat_q <= STAT_OK;
    end else begin
      state <= state_next;
      if (acc) begin
        if (last) begin
          n_q     <= room ? len + CNT_W'(1) : len;
          layer_q <= layer;
          stat_q  <= batch_stat;
          len     <= '0;
          ovf     <= 1'b0;
          bad     <= 1'b0;
          pos     <= '0;
          used    <= '0;
          if (!ovf_all && (layer < layer_count) && !sticky && bad_all) sticky <= 1'b1;
        end else begin
          if (id_bad) bad <= 1'b1;
          if (room) begin
            len <= len + CNT_W'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
      end
      if (pos_step) pos <= last_pos ? '0 : pos + CNT_W'(1);
      if (state == ST_ID_RD) s <= '0;
      if (state == ST_TAB_CMP && !match) s <= s + CNT_W'(1);
      if (tab_we) used <= used + CNT_W'(1);
    end
  end

  assign off_req.layer  = layer_q;
  assign off_req.expert = UEXP_W'(tab_q);

  // result fields straight from registers
  assign position      = POS_W'(pos);
  assign mapped_slot   = (batch_ok && sb_q[SI_W+1]) ? SLOT_W'(sb_q[SI_W-1:0]) : SLOT_NONE;
  assign new_entry     = batch_ok && sb_q[SI_W];
  assign unique_expert = new_entry ? UEXP_W'(tab_q) : '0;
  assign record_offset = new_entry ? off_data : '0;
  assign unique_total  = batch_ok ? TOT_W'(used) : '0;
  assign status        = stat_q;
  assign final_res     = last_pos;

endmodule

// File: hdl/expert_route_dedup_offset_top.sv
// ----------------------------------------------------------------------------
// expert_route_dedup_offset_top
// Expert id batch checker, first-occurrence dedup and record offset generator.
// ----------------------------------------------------------------------------
// Collect: one id per cycle while idle; the last id starts batch processing.
// Scan: per position read the id, then compare table entries until hit or new.
// Emit: memory reads, plus the 2-stage offset mult for a new entry. Error
// batches: one result per unstalled cycle. No input taken until emission ends.
// Sync reset: clears batch, sticky failure and loads config reset values.
// ----------------------------------------------------------------------------
module expert_route_dedup_offset_top #(
  parameter int SLOTS   = 9,
  parameter int EXPERTS = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [erdo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [erdo_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [erdo_pkg::ID_W-1:0]        expert_id,
  input  logic [erdo_pkg::LAYER_W-1:0]     layer,
  input  logic                             last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [erdo_pkg::POS_W-1:0]       position,
  output logic [erdo_pkg::SLOT_W-1:0]      mapped_slot,
  output logic                             new_entry,
  output logic [erdo_pkg::UEXP_W-1:0]      unique_expert,
  output logic [erdo_pkg::OFF_W-1:0]       record_offset,
  output logic [erdo_pkg::TOT_W-1:0]       unique_total,
  output logic [1:0]                       status,
  output logic                             final_res
);
  import erdo_pkg::*;

  logic [CFG_W-1:0]   record_size;
  logic [LAYER_W-1:0] layer_count;
  off_req_t           off_req;
  logic [OFF_W-1:0]   off_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_size <= RECORD_SIZE_RST;
      layer_count <= LAYER_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RECORD_SIZE: record_size <= cfg_data;
        CFG_LAYER_COUNT: layer_count <= cfg_data[LAYER_W-1:0];
        default: ;
      endcase
    end
  end

  erdo_core #(
    .SLOTS   (SLOTS),
    .EXPERTS (EXPERTS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .expert_id     (expert_id),
    .layer         (layer),
    .last          (last),
    .layer_count   (layer_count),
    .off_req       (off_req),
    .off_data      (off_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .position      (position),
    .mapped_slot   (mapped_slot),
    .new_entry     (new_entry),
    .unique_expert (unique_expert),
    .record_offset (record_offset),
    .unique_total  (unique_total),
    .status        (status),
    .final_res     (final_res)
  );

  erdo_offset #(
    .EXPERTS (EXPERTS)
  ) u_offset (
    .clk         (clk),
    .req         (off_req),
    .record_size (record_size),
    .offset      (off_data)
  );

endmodule

// File: test/tb_expert_route_dedup_offset_top.sv
// ----------------------------------------------------------------------------
// tb_expert_route_dedup_offset_top
// Self-checking bench for the expert route dedup / record offset block.
// A table of directed batches walks the edge cases. Random batches then run
// under several register settings. A second predictor of the batch
// dedup/offset logic checks every result transaction field by field.
// Random gaps and stalls sit on both channels, and one long receiver
// hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_expert_route_dedup_offset_top;
  import erdo_pkg::*;

  localparam int SLOTS        = 9;
  localparam int EXPERTS      = 128;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int SETTLE       = 12;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 36;
  localparam int POISON_ITEMS = 24;
  localparam int HEAD_ROWS    = 26;
  localparam int ROW_COUNT    = 30;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [SLOT_W-1:0] slot;
    logic              fresh;
    logic [UEXP_W-1:0] uexp;
    logic [OFF_W-1:0]  off;
    logic [TOT_W-1:0]  total;
    status_t           stat;
    logic              fin;
  } route_result_t;

  // one input transaction; pin marks rows whose slot/status is typed in
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LAYER_W-1:0] lay;
    logic               fin;
    logic               pin;
    logic [SLOT_W-1:0]  slot;
    status_t            stat;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [ROW_COUNT] = '{
    // lone id right after reset, reset config (layer_count 3)
    '{16'h0000, 8'd0,   1'b1, 1'b1, 7'd0,      STAT_OK},
    // max id twice around an inactive id, top legal layer on the last item
    '{16'h007F, 8'd7,   1'b0, 1'b1, 7'd0,      STAT_OK},
    '{16'hFFFF, 8'd0,   1'b0, 1'b1, SLOT_NONE, STAT_OK},
    '{16'h007F, 8'd2,   1'b1, 1'b1, 7'd0,      STAT_OK},
    // bad layer hides a bad id, so no sticky failure
    '{16'h8000, 8'd3,   1'b1, 1'b1, SLOT_NONE, STAT_INVALID},
    '{16'h7FFF, 8'd255, 1'b1, 1'b1, SLOT_NONE, STAT_INVALID},
    // batch of only an inactive id
    '{16'hFFFF, 8'd0,   1'b1, 1'b1, SLOT_NONE, STAT_OK},
    // ten ids: overflow, bad id among them but no sticky mark
    '{16'h0000, 8'd1,   1'b0, 1'b1, SLOT_NONE, STAT_INVALID},
    '{16'h0001, 8'd1,   1'b0, 1'b0, SLOT_NONE, STAT_OK},
    '{16'h0080, 8'd1,   1'b0, 1'b0, SLOT_NONE, STAT_OK},
    '{16'h0003, 8'd1,   1'b0, 1'b0, SLOT_NONE, STAT_OK},
    '{16'h0004, 8'd1,   1'b0, 1'b0, SLOT_NONE, STAT_OK},
    '{16'h0005, 8'd1,   1'b0, 1'b0, SLOT_NONE, STAT_OK},
    '{16'h0006, 8'd1,   1'b0, 1'b0, SLOT_NONE, STAT_OK},
    '{16'h0007, 8'd1,   1'b0, 1'b0, SLOT_NONE, STAT_OK},
    '{16'h0008, 8'd1,   1'b0, 1'b1, SLOT_NONE, STAT_INVALID},
    '{16'h0009, 8'd1,   1'b1, 1'b0, SLOT_NONE, STAT_OK},
    // nine distinct ids: every slot used
    '{16'h007F, 8'd0,   1'b0, 1'b1, 7'd0,      STAT_OK},
    '{16'h007E, 8'd0,   1'b0, 1'b0, 7'd0,      STAT_OK},
    '{16'h007D, 8'd0,   1'b0, 1'b0, 7'd0,      STAT_OK},
    '{16'h007C, 8'd0,   1'b0, 1'b0, 7'd0,      STAT_OK},
    '{16'h007B, 8'd0,   1'b0, 1'b0, 7'd0,      STAT_OK},
    '{16'h007A, 8'd0,   1'b0, 1'b0, 7'd0,      STAT_OK},
    '{16'h0079, 8'd0,   1'b0, 1'b0, 7'd0,      STAT_OK},
    '{16'h0078, 8'd0,   1'b0, 1'b0, 7'd0,      STAT_OK},
    '{16'h0077, 8'd2,   1'b1, 1'b1, 7'd8,      STAT_OK},
    // played after the random part: bad id sets the sticky failure
    '{16'h0005, 8'd0,   1'b0, 1'b1, SLOT_NONE, STAT_INVALID},
    '{16'hFFFE, 8'd0,   1'b1, 1'b1, SLOT_NONE, STAT_INVALID},
    '{16'h0007, 8'd0,   1'b1, 1'b1, SLOT_NONE, STAT_POISON},
    // bad layer still wins over poisoned
    '{16'h0001, 8'd3,   1'b1, 1'b1, SLOT_NONE, STAT_INVALID}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [ID_W-1:0]      expert_id;
  logic [LAYER_W-1:0]   layer;
  logic                 last;
  logic                 out_valid;
  logic                 out_stall;
  logic [POS_W-1:0]     position;
  logic [SLOT_W-1:0]    mapped_slot;
  logic                 new_entry;
  logic [UEXP_W-1:0]    unique_expert;
  logic [OFF_W-1:0]     record_offset;
  logic [TOT_W-1:0]     unique_total;
  logic [1:0]           status;
  logic                 final_res;

  // predictor copy of the block's state and registers
  int                   batch_ids [SLOTS];
  int                   batch_len;
  bit                   batch_over;
  bit                   batch_bad;
  bit                   sticky;
  logic [CFG_W-1:0]     rec_size;
  logic [LAYER_W-1:0]   layer_cnt;

  route_result_t        route_expect_q [$];
  route_result_t        batch_res [SLOTS];
  int                   batch_n;
  route_result_t        next_route;

  logic                 pin_on [SLOTS];
  logic [SLOT_W-1:0]    pin_slot [SLOTS];
  status_t              pin_stat [SLOTS];

  idle_mode_t           in_mode;
  idle_mode_t           out_mode;
  bit                   hold_req;
  int                   stall_left;

  int mismatches;
  int items_sent;
  int batches_sent;
  int results_seen;
  int seen_ok;
  int seen_invalid;
  int seen_poison;
  int cfg_writes;
  int holds_done;
  int quiet;

  expert_route_dedup_offset_top #(
    .SLOTS   (SLOTS),
    .EXPERTS (EXPERTS)
  ) i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap(idle_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_LIGHT: begin
        if (r < 75) return 0;
        else if (r < 96) return $urandom_range(1, 3);
        else return $urandom_range(8, 30);
      end
      default: begin
        if (r < 45) return 0;
        else if (r < 92) return $urandom_range(1, 4);
        else return $urandom_range(10, 40);
      end
    endcase
  endfunction

  // batch collect / validate / first-occurrence dedup / offset
  task automatic route_dedup_predict(input logic [ID_W-1:0] raw,
                                     input logic [LAYER_W-1:0] lay,
                                     input logic fin_item);
    int            id;
    int            n;
    int            used;
    int            s;
    int            utab [SLOTS];
    status_t       st;
    route_result_t r;
    logic [63:0]   prod;
    id = int'($signed(raw));
    if (id < -1 || id >= EXPERTS) batch_bad = 1'b1;
    if (batch_len < SLOTS) begin
      batch_ids[batch_len] = id;
      batch_len++;
    end else begin
      batch_over = 1'b1;
    end
    if (!fin_item) return;

    n  = batch_len;
    st = STAT_OK;
    if (batch_over || lay >= layer_cnt) st = STAT_INVALID;
    else if (sticky) st = STAT_POISON;
    else if (batch_bad) begin
      sticky = 1'b1;
      st     = STAT_INVALID;
    end

    used = 0;
    for (int i = 0; i < n; i++) begin
      r.pos   = POS_W'(i);
      r.slot  = SLOT_NONE;
      r.fresh = 1'b0;
      r.uexp  = '0;
      r.off   = '0;
      r.total = '0;
      r.stat  = st;
      r.fin   = (i == n - 1);
      if (st == STAT_OK && batch_ids[i] >= 0) begin
        s = 0;
        while (s < used && utab[s] != batch_ids[i]) s++;
        if (s == used) begin
          utab[used] = batch_ids[i];
          used++;
          r.fresh = 1'b1;
          r.uexp  = UEXP_W'(batch_ids[i]);
          prod    = (64'(lay) * 64'(EXPERTS) + 64'(batch_ids[i])) * 64'(rec_size);
          r.off   = prod[OFF_W-1:0];
        end
        r.slot = SLOT_W'(s);
      end
      batch_res[i] = r;
    end
    for (int i = 0; i < n; i++) begin
      if (st == STAT_OK) batch_res[i].total = TOT_W'(used);
      route_expect_q.push_back(batch_res[i]);
    end
    batch_n    = n;
    batch_len  = 0;
    batch_over = 1'b0;
    batch_bad  = 1'b0;
    batches_sent++;
  endtask

  task automatic push_item(input logic [ID_W-1:0] id_v, input logic [LAYER_W-1:0] lay_v,
                           input logic fin_v);
    int gap;
    gap = draw_gap(in_mode);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  = 1'b1;
    expert_id = id_v;
    layer     = lay_v;
    last      = fin_v;
    do @(posedge clk); while (in_stall);
    items_sent++;
    route_dedup_predict(id_v, lay_v, fin_v);
  endtask

  task automatic play_row(input dir_row_t row);
    if (row.pin && batch_len < SLOTS) begin
      pin_on[batch_len]   = 1'b1;
      pin_slot[batch_len] = row.slot;
      pin_stat[batch_len] = row.stat;
    end
    push_item(row.id, row.lay, row.fin);
    if (row.fin) begin
      for (int i = 0; i < batch_n; i++) begin
        if (pin_on[i] && (pin_slot[i] !== batch_res[i].slot ||
                          pin_stat[i] !== batch_res[i].stat)) begin
          mismatches++;
          $display("%0t directed position %0d: expected slot %0h status %0d, got %0h %0d",
                   $time, i, pin_slot[i], pin_stat[i], batch_res[i].slot, batch_res[i].stat);
        end
        pin_on[i] = 1'b0;
      end
    end
  endtask

  // mostly well-formed batches with repeated ids; the rest overflow or bad layer
  task automatic send_random_batch(inout int sent);
    int                 kind;
    int                 len;
    int                 pool [3];
    int                 r;
    bit                 legal;
    logic [ID_W-1:0]    idv;
    logic [LAYER_W-1:0] lay_last;
    kind = $urandom_range(0, 99);
    for (int k = 0; k < 3; k++) pool[k] = $urandom_range(0, EXPERTS - 1);
    if (kind >= 75 && kind < 88) len = $urandom_range(SLOTS + 1, SLOTS + 5);
    else len = $urandom_range(1, SLOTS);
    if (kind < 75 && layer_cnt > 0) lay_last = LAYER_W'($urandom_range(0, layer_cnt - 1));
    else if (kind >= 88) lay_last = LAYER_W'($urandom_range(layer_cnt, 255));
    else lay_last = LAYER_W'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      legal = (kind < 75) || ($urandom_range(0, 1) == 0);
      r = $urandom_range(0, 9);
      if (!legal) idv = ID_W'($urandom_range(0, 16'hFFFF));
      else if (r == 0) idv = 16'hFFFF;
      else if (r < 6) idv = ID_W'(pool[r % 3]);
      else if (r == 6) idv = ID_W'(EXPERTS - 1);
      else if (r == 7) idv = '0;
      else idv = ID_W'($urandom_range(0, EXPERTS - 1));
      push_item(idv, (i == len - 1) ? lay_last : LAYER_W'($urandom_range(0, 255)),
                i == len - 1);
    end
    sent += len;
  endtask

  // drop valid, wait for every expected result, then let the block go idle
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    last     = 1'b0;
    while (route_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_RECORD_SIZE) rec_size = data;
    else if (idx == CFG_LAYER_COUNT) layer_cnt = data[LAYER_W-1:0];
    cfg_writes++;
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s: expected %0h got %0h", $time, fname, want, got);
    end
  endtask

  // receiver stall; one requested hold-off is counted out here
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_CYCLES;
      holds_done++;
    end else if (stall_left == 0) begin
      stall_left = draw_gap(out_mode);
    end
    out_stall = (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (route_expect_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, got position %0d slot %0h status %0d",
                 $time, position, mapped_slot, status);
      end else begin
        next_route = route_expect_q.pop_front();
        check_field("position", 64'(next_route.pos), 64'(position));
        check_field("mapped_slot", 64'(next_route.slot), 64'(mapped_slot));
        check_field("new_entry", 64'(next_route.fresh), 64'(new_entry));
        check_field("unique_expert", 64'(next_route.uexp), 64'(unique_expert));
        check_field("record_offset", 64'(next_route.off), 64'(record_offset));
        check_field("unique_total", 64'(next_route.total), 64'(unique_total));
        check_field("status", 64'(next_route.stat), 64'(status));
        check_field("final_res", 64'(next_route.fin), 64'(final_res));
        results_seen++;
        if (status == STAT_OK) seen_ok++;
        else if (status == STAT_INVALID) seen_invalid++;
        else seen_poison++;
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d quiet cycles", QUIET_LIMIT);
    $display("expert_route_dedup_offset_top: mismatch");
    $finish;
  end

  initial begin
    int                 sent;
    logic [CFG_W-1:0]   rs;
    logic [LAYER_W-1:0] lc;
    clk        = 1'b0;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    expert_id  = '0;
    layer      = '0;
    last       = 1'b0;
    out_stall  = 1'b0;
    stall_left = 0;
    hold_req   = 1'b0;
    in_mode    = IDLE_LIGHT;
    out_mode   = IDLE_LIGHT;
    batch_len  = 0;
    batch_over = 1'b0;
    batch_bad  = 1'b0;
    sticky     = 1'b0;
    rec_size   = RECORD_SIZE_RST;
    layer_cnt  = LAYER_COUNT_RST;
    for (int i = 0; i < SLOTS; i++) pin_on[i] = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < HEAD_ROWS; r++) play_row(DIR_ROWS[r]);

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      case (p)
        0: begin rs = '1;              lc = 8'd255; end
        1: begin rs = 32'd1;           lc = 8'd1;   end
        2: begin rs = $urandom();      lc = 8'd0;   end
        3: begin rs = RECORD_SIZE_RST; lc = LAYER_W'($urandom_range(1, 255)); end
        default: begin
          rs = $urandom_range(1, 32'hFFFF_FFFF);
          lc = LAYER_W'($urandom_range(1, 255));
        end
      endcase
      write_cfg(CFG_RECORD_SIZE, rs);
      write_cfg(CFG_LAYER_COUNT, CFG_W'(lc));
      in_mode  = idle_mode_t'(p % 3);
      out_mode = idle_mode_t'((p + p / 3) % 3);
      // sender runs gap-free here while the receiver holds off
      if (p == 3) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_batch(sent);
    end

    // sticky failure last: from here on every healthy batch is poisoned
    quiesce();
    write_cfg(CFG_LAYER_COUNT, CFG_W'(LAYER_COUNT_RST));
    in_mode  = IDLE_LIGHT;
    out_mode = IDLE_HEAVY;
    for (int r = HEAD_ROWS; r < ROW_COUNT; r++) play_row(DIR_ROWS[r]);
    sent = 0;
    while (sent < POISON_ITEMS) send_random_batch(sent);
    quiesce();

    $display("covered %0d id transactions in %0d batches, %0d results",
             items_sent, batches_sent, results_seen);
    $display("(%0d ok, %0d invalid, %0d poisoned), %0d register writes over %0d settings",
             seen_ok, seen_invalid, seen_poison, cfg_writes, PHASES + 1);
    $display("%0d long receiver hold-off", holds_done);
    if (mismatches == 0) begin
      $display("expert_route_dedup_offset_top: match");
    end else begin
      $display("expert_route_dedup_offset_top: mismatch");
    end
    $finish;
  end

endmodule

// File: expert_route_dedup_offset_top.f
hdl/erdo_pkg.sv
hdl/erdo_offset.sv
hdl/erdo_core.sv
hdl/expert_route_dedup_offset_top.sv
test/tb_expert_route_dedup_offset_top.sv
